// ----- design/rlum_pkg.sv -----
// Shared constants, operation codes and control/status structs for the radial undistortion map.
package rlum_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int HEIGHT_W    = 24;
   localparam int ENTRY_W     = 2 * HEIGHT_W;
   localparam int SQRT_STEPS  = 30;
   localparam int DIV_STEPS   = 25;
   localparam int CNT_W       = 5;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_OUT_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_OUT_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_INV_SCALE   = 3'd2;
   localparam logic [2:0] CSR_SRC_WIDTH   = 3'd3;
   localparam logic [2:0] CSR_SRC_HEIGHT  = 3'd4;
   localparam logic [2:0] CSR_TABLE_COUNT = 3'd5;

   // datapath operations
   localparam logic [4:0] OP_NONE       = 5'd0;
   localparam logic [4:0] OP_MUL_X      = 5'd1;
   localparam logic [4:0] OP_MUL_Y      = 5'd2;
   localparam logic [4:0] OP_SQ_X       = 5'd3;
   localparam logic [4:0] OP_SQ_Y       = 5'd4;
   localparam logic [4:0] OP_SUM        = 5'd5;
   localparam logic [4:0] OP_SQRT_INIT  = 5'd6;
   localparam logic [4:0] OP_SQRT_STEP  = 5'd7;
   localparam logic [4:0] OP_CAP_L      = 5'd8;
   localparam logic [4:0] OP_CAP_R      = 5'd9;
   localparam logic [4:0] OP_TRIV       = 5'd10;
   localparam logic [4:0] OP_IMUL       = 5'd11;
   localparam logic [4:0] OP_DIV_LOAD   = 5'd12;
   localparam logic [4:0] OP_DIV_STEP   = 5'd13;
   localparam logic [4:0] OP_RD_SET     = 5'd14;
   localparam logic [4:0] OP_XMUL       = 5'd15;
   localparam logic [4:0] OP_YMUL       = 5'd16;
   localparam logic [4:0] OP_MX_SET     = 5'd17;
   localparam logic [4:0] OP_MY_SET     = 5'd18;
   localparam logic [4:0] OP_CENTER     = 5'd19;
   localparam logic [4:0] OP_OUT        = 5'd20;

   typedef struct packed {
      logic              accept;
      logic [4:0]        op;
      logic [ADDR_W-1:0] ram_addr;
   } ctrl_type;

   typedef struct packed {
      logic              is_map;
      logic              r_zero;
      logic              ge_last;
      logic              le_cur;
      logic              trivial;
      logic              out_free;
      logic [ADDR_W-1:0] n_last;
   } status_type;

endpackage

// ----- design/rlum_ram.sv -----
// Generic single-port-write, registered-read RAM.
module rlum_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/rlum_ctrl.sv -----
// Sequencer for the radial undistortion map: issues datapath operations per state.
module rlum_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rlum_pkg::status_type status,
   output rlum_pkg::ctrl_type   ctrl
);
   import rlum_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MX   = 5'd1;
   localparam logic [4:0] S_MY   = 5'd2;
   localparam logic [4:0] S_SQX  = 5'd3;
   localparam logic [4:0] S_SQY  = 5'd4;
   localparam logic [4:0] S_SUM  = 5'd5;
   localparam logic [4:0] S_SQI  = 5'd6;
   localparam logic [4:0] S_SQS  = 5'd7;
   localparam logic [4:0] S_RDL  = 5'd8;
   localparam logic [4:0] S_CKL  = 5'd9;
   localparam logic [4:0] S_WRD  = 5'd10;
   localparam logic [4:0] S_WCK  = 5'd11;
   localparam logic [4:0] S_SL   = 5'd12;
   localparam logic [4:0] S_SR   = 5'd13;
   localparam logic [4:0] S_SRC  = 5'd14;
   localparam logic [4:0] S_INT  = 5'd15;
   localparam logic [4:0] S_DAL  = 5'd16;
   localparam logic [4:0] S_DAS  = 5'd17;
   localparam logic [4:0] S_RDS  = 5'd18;
   localparam logic [4:0] S_XM   = 5'd19;
   localparam logic [4:0] S_DXL  = 5'd20;
   localparam logic [4:0] S_DXS  = 5'd21;
   localparam logic [4:0] S_XS   = 5'd22;
   localparam logic [4:0] S_YM   = 5'd23;
   localparam logic [4:0] S_DYL  = 5'd24;
   localparam logic [4:0] S_DYS  = 5'd25;
   localparam logic [4:0] S_YS   = 5'd26;
   localparam logic [4:0] S_OUT  = 5'd27;

   logic [4:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] seg_ff, seg_in;
   logic              cnt_sqrt_last;
   logic              cnt_div_last;

   assign cnt_sqrt_last = (cnt_ff == CNT_W'(SQRT_STEPS - 1));
   assign cnt_div_last  = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign req_ready     = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      seg_in        = seg_ff;
      ctrl.accept   = 1'b0;
      ctrl.op       = OP_NONE;
      ctrl.ram_addr = seg_ff;
      case (state_ff)
         S_IDLE: begin
            ctrl.accept = req_valid;
            if (req_valid && status.is_map) begin
               state_in = S_MX;
            end
         end
         S_MX:  begin ctrl.op = OP_MUL_X; state_in = S_MY; end
         S_MY:  begin ctrl.op = OP_MUL_Y; state_in = S_SQX; end
         S_SQX: begin ctrl.op = OP_SQ_X;  state_in = S_SQY; end
         S_SQY: begin ctrl.op = OP_SQ_Y;  state_in = S_SUM; end
         S_SUM: begin ctrl.op = OP_SUM;   state_in = S_SQI; end
         S_SQI: begin
            ctrl.op  = OP_SQRT_INIT;
            cnt_in   = '0;
            state_in = S_SQS;
         end
         S_SQS: begin
            ctrl.op = OP_SQRT_STEP;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_sqrt_last) begin
               state_in = S_RDL;
            end
         end
         S_RDL: begin
            ctrl.ram_addr = status.n_last;
            if (status.r_zero) begin
               ctrl.op  = OP_CENTER;
               state_in = S_OUT;
            end else begin
               state_in = S_CKL;
            end
         end
         // take the last segment at once when r is past it or it is the only one
         S_CKL: begin
            if (status.ge_last || (status.n_last == '0)) begin
               seg_in   = status.n_last;
               state_in = S_SL;
            end else begin
               seg_in   = '0;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            ctrl.ram_addr = seg_ff + 1'b1;
            state_in      = S_WCK;
         end
         // stop at the first upper bound that covers r, or at the last segment
         S_WCK: begin
            if (status.le_cur) begin
               state_in = S_SL;
            end else begin
               seg_in = seg_ff + 1'b1;
               if (seg_ff + 1'b1 == status.n_last) begin
                  state_in = S_SL;
               end else begin
                  state_in = S_WRD;
               end
            end
         end
         S_SL: begin
            ctrl.ram_addr = seg_ff;
            state_in      = S_SR;
         end
         S_SR: begin
            ctrl.ram_addr = seg_ff + 1'b1;
            ctrl.op       = OP_CAP_L;
            state_in      = S_SRC;
         end
         S_SRC: begin ctrl.op = OP_CAP_R; state_in = S_INT; end
         S_INT: begin
            if (status.trivial) begin
               ctrl.op  = OP_TRIV;
               state_in = S_XM;
            end else begin
               ctrl.op  = OP_IMUL;
               state_in = S_DAL;
            end
         end
         S_DAL: begin ctrl.op = OP_DIV_LOAD; cnt_in = '0; state_in = S_DAS; end
         S_DAS: begin
            ctrl.op = OP_DIV_STEP;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_div_last) begin
               state_in = S_RDS;
            end
         end
         S_RDS: begin ctrl.op = OP_RD_SET; state_in = S_XM; end
         S_XM:  begin ctrl.op = OP_XMUL; state_in = S_DXL; end
         S_DXL: begin ctrl.op = OP_DIV_LOAD; cnt_in = '0; state_in = S_DXS; end
         S_DXS: begin
            ctrl.op = OP_DIV_STEP;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_div_last) begin
               state_in = S_XS;
            end
         end
         S_XS:  begin ctrl.op = OP_MX_SET; state_in = S_YM; end
         S_YM:  begin ctrl.op = OP_YMUL; state_in = S_DYL; end
         S_DYL: begin ctrl.op = OP_DIV_LOAD; cnt_in = '0; state_in = S_DYS; end
         S_DYS: begin
            ctrl.op = OP_DIV_STEP;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_div_last) begin
               state_in = S_YS;
            end
         end
         S_YS:  begin ctrl.op = OP_MY_SET; state_in = S_OUT; end
         // hold until the output register is free
         S_OUT: begin
            if (status.out_free) begin
               ctrl.op  = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         seg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         seg_ff   <= seg_in;
      end
   end
endmodule

// ----- design/rlum_dp.sv -----
// Datapath: registers, table RAM, multiplier, square-root and divider steps.
module rlum_dp (
   input  logic                clock,
   input  logic                reset,
   input  rlum_pkg::ctrl_type   ctrl,
   output rlum_pkg::status_type status,
   input  logic                req_mode,
   input  logic [5:0]          req_entry_index,
   input  logic [23:0]         req_undistorted_height,
   input  logic [23:0]         req_distorted_height,
   input  logic [11:0]         req_col,
   input  logic [11:0]         req_row,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [23:0]  rsp_map_x,
   output logic signed [23:0]  rsp_map_y,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);
   import rlum_pkg::*;

   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      logic signed [23:0] res;
      if (v > 27'sd8388607) begin
         res = 24'sh7FFFFF;
      end else if (v < -27'sd8388608) begin
         res = 24'sh800000;
      end else begin
         res = v[23:0];
      end
      return res;
   endfunction

   logic [12:0] ow_ff, oh_ff, sw_ff, sh_ff;
   logic [15:0] inv_ff;
   logic [6:0]  tc_ff;
   logic [11:0] col_ff, row_ff;
   logic signed [30:0] x_ff, y_ff;
   logic signed [61:0] prod_ff;
   logic [59:0] sqv_ff;
   logic [32:0] srem_ff;
   logic [29:0] root_ff;
   logic [23:0] ul_ff, dl_ff, ur_ff, dr_ff, rd_ff;
   logic [29:0] dvs_ff, drem_ff;
   logic [24:0] dquo_ff;
   logic        neg_ff;
   logic signed [23:0] mx_ff, my_ff, rsp_x_ff, rsp_y_ff;
   logic        rsp_valid_ff;

   logic              wr_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [23:0]       ram_u;
   logic [29:0]       two_u;
   logic signed [13:0] dx, dy;
   logic signed [16:0] inv_s;
   logic [32:0] sq_t, sq_trial;
   logic [29:0] xl, xr;
   logic [23:0] yl1, yr1;
   logic signed [30:0] den;
   logic signed [24:0] dyv;
   logic signed [30:0] drv;
   logic [61:0] mag;
   logic [55:0] num;
   logic [30:0] dv_t;
   logic        dv_ge;
   logic signed [25:0] q_s;
   logic signed [25:0] rd_sum;
   logic signed [26:0] mx_sum, my_sum;
   logic [6:0]  n_cl;

   // table RAM: {undistorted, distorted}
   assign wr_en = ctrl.accept && !req_mode
                  && ({1'b0, req_entry_index} < 7'(TABLE_DEPTH));
   rlum_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index[ADDR_W-1:0]),
      .wr_data ({req_undistorted_height, req_distorted_height}),
      .rd_addr (ctrl.ram_addr),
      .rd_data (rd_data)
   );
   assign ram_u = rd_data[ENTRY_W-1:HEIGHT_W];
   assign two_u = 30'({ram_u, 1'b0});

   // centered, scaled offsets
   assign inv_s = signed'({1'b0, inv_ff});
   assign dx    = signed'({1'b0, col_ff, 1'b0}) - signed'({1'b0, ow_ff});
   assign dy    = signed'({1'b0, row_ff, 1'b0}) - signed'({1'b0, oh_ff});

   // square-root digit step
   assign sq_t     = {srem_ff[30:0], sqv_ff[59:58]};
   assign sq_trial = {1'b0, root_ff, 2'b01};

   // segment end points with clamping
   assign xl  = 30'({ul_ff, 1'b0});
   assign xr  = 30'({ur_ff, 1'b0});
   assign yr1 = (root_ff < xl) ? dl_ff : dr_ff;
   assign yl1 = (root_ff > xr) ? yr1 : dl_ff;
   assign den = signed'({1'b0, xr}) - signed'({1'b0, xl});
   assign dyv = signed'({1'b0, yr1}) - signed'({1'b0, yl1});
   assign drv = signed'({1'b0, root_ff - xl});

   // divider: rounded magnitude, then one quotient bit a step
   assign mag   = prod_ff[61] ? 62'(-prod_ff) : 62'(prod_ff);
   assign num   = mag[55:0] + 56'(dvs_ff >> 1);
   assign dv_t  = {drem_ff, dquo_ff[24]};
   assign dv_ge = (dv_t >= {1'b0, dvs_ff});
   assign q_s   = neg_ff ? -signed'({1'b0, dquo_ff}) : signed'({1'b0, dquo_ff});

   assign rd_sum = signed'({2'b0, yl1}) + q_s;
   assign mx_sum = 27'(q_s) + signed'(27'({sw_ff, 7'b0}));
   assign my_sum = 27'(q_s) + signed'(27'({sh_ff, 7'b0}));

   // clamp entry count to [2, depth]
   always_comb begin
      if (tc_ff < 7'd2) begin
         n_cl = 7'd2;
      end else if (tc_ff > 7'(TABLE_DEPTH)) begin
         n_cl = 7'(TABLE_DEPTH);
      end else begin
         n_cl = tc_ff;
      end
   end

   assign status.is_map   = req_mode;
   assign status.r_zero   = (root_ff == '0);
   assign status.ge_last  = (root_ff >= two_u);
   assign status.le_cur   = (root_ff <= two_u);
   assign status.trivial  = (yl1 == yr1) || (den <= 0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.n_last   = ADDR_W'(n_cl - 7'd2);

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         ow_ff  <= 13'd480;
         oh_ff  <= 13'd270;
         inv_ff <= 16'd1024;
         sw_ff  <= 13'd1920;
         sh_ff  <= 13'd1080;
         tc_ff  <= 7'd64;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OUT_WIDTH:   ow_ff  <= csr_data[12:0];
            CSR_OUT_HEIGHT:  oh_ff  <= csr_data[12:0];
            CSR_INV_SCALE:   inv_ff <= csr_data;
            CSR_SRC_WIDTH:   sw_ff  <= csr_data[12:0];
            CSR_SRC_HEIGHT:  sh_ff  <= csr_data[12:0];
            CSR_TABLE_COUNT: tc_ff  <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         col_ff <= req_col;
         row_ff <= req_row;
      end
      case (ctrl.op)
         OP_MUL_X: x_ff <= dx * inv_s;
         OP_MUL_Y: y_ff <= dy * inv_s;
         OP_SQ_X:  prod_ff <= x_ff * x_ff;
         OP_SQ_Y: begin
            sqv_ff  <= prod_ff[59:0];
            prod_ff <= y_ff * y_ff;
         end
         OP_SUM: sqv_ff <= sqv_ff + prod_ff[59:0];
         OP_SQRT_INIT: begin
            srem_ff <= '0;
            root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            sqv_ff <= {sqv_ff[57:0], 2'b00};
            if (sq_t >= sq_trial) begin
               srem_ff <= sq_t - sq_trial;
               root_ff <= {root_ff[28:0], 1'b1};
            end else begin
               srem_ff <= sq_t;
               root_ff <= {root_ff[28:0], 1'b0};
            end
         end
         OP_CAP_L: begin
            ul_ff <= rd_data[ENTRY_W-1:HEIGHT_W];
            dl_ff <= rd_data[HEIGHT_W-1:0];
         end
         OP_CAP_R: begin
            ur_ff <= rd_data[ENTRY_W-1:HEIGHT_W];
            dr_ff <= rd_data[HEIGHT_W-1:0];
         end
         OP_TRIV: rd_ff <= yl1;
         OP_IMUL: begin
            prod_ff <= 62'(dyv * drv);
            dvs_ff  <= den[29:0];
         end
         OP_DIV_LOAD: begin
            neg_ff  <= prod_ff[61];
            drem_ff <= num[54:25];
            dquo_ff <= num[24:0];
         end
         OP_DIV_STEP: begin
            drem_ff <= dv_ge ? 30'(dv_t - {1'b0, dvs_ff}) : dv_t[29:0];
            dquo_ff <= {dquo_ff[23:0], dv_ge};
         end
         OP_RD_SET: rd_ff <= rd_sum[23:0];
         OP_XMUL: begin
            prod_ff <= 62'(x_ff * signed'({1'b0, rd_ff}));
            dvs_ff  <= root_ff;
         end
         OP_YMUL: begin
            prod_ff <= 62'(y_ff * signed'({1'b0, rd_ff}));
            dvs_ff  <= root_ff;
         end
         OP_MX_SET: mx_ff <= sat24(mx_sum);
         OP_MY_SET: my_ff <= sat24(my_sum);
         OP_CENTER: begin
            mx_ff <= signed'(24'({sw_ff, 7'b0}));
            my_ff <= signed'(24'({sh_ff, 7'b0}));
         end
         OP_OUT: begin
            rsp_x_ff <= mx_ff;
            rsp_y_ff <= my_ff;
         end
         default: begin
         end
      endcase
   end

   // output transaction valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_map_x = rsp_x_ff;
   assign rsp_map_y = rsp_y_ff;
endmodule

// ----- design/radial_lut_undistort_map.sv -----
// Top level of the radial table lens undistortion map.
// A load transaction (mode 0) writes one table entry in its accept cycle and the block is ready
// again at once. A map transaction (mode 1), once accepted, passes through offset and square
// forming, a bit-serial square root, the last-entry test, a walk over up to the clamped entry
// count minus two table entries, the segment fetch, the interpolation division, the two
// coordinate multiply-divides on one shared restoring divider, and the move into the output
// register. A clamped or flat segment skips the interpolation division, and a zero radius
// gives the source center. The worst case is set by the serial square root, the divider and
// the table walk through the single RAM read port. A finished result waits in an output
// register; a new transaction is taken once the sequencer is back in idle, in the cycle in
// which the result becomes valid in that register, later if the previous result there has not
// yet been accepted. Entries read before they were written give undefined results.
module radial_lut_undistort_map (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [5:0]         req_entry_index,
   input  logic [23:0]        req_undistorted_height,
   input  logic [23:0]        req_distorted_height,
   input  logic [11:0]        req_col,
   input  logic [11:0]        req_row,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_map_x,
   output logic signed [23:0] rsp_map_y,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import rlum_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   rlum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   rlum_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .ctrl                   (ctrl),
      .status                 (status),
      .req_mode               (req_mode),
      .req_entry_index        (req_entry_index),
      .req_undistorted_height (req_undistorted_height),
      .req_distorted_height   (req_distorted_height),
      .req_col                (req_col),
      .req_row                (req_row),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_map_x              (rsp_map_x),
      .rsp_map_y              (rsp_map_y),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );
endmodule

// ----- bench/radial_lut_undistort_map_test.sv -----
// Testbench for the radial table undistortion map: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module radial_lut_undistort_map_test;
   import rlum_pkg::*;

   typedef struct {
      logic [23:0] map_x;
      logic [23:0] map_y;
   } map_point_type;

   // scoreboard: predicts map points for accepted transactions and checks results
   class map_scoreboard;
      logic [23:0] und_tab [TABLE_DEPTH];
      logic [23:0] dis_tab [TABLE_DEPTH];
      int unsigned out_w, out_h, scale, src_w, src_h, tab_n;
      map_point_type pending[$];
      int mismatches;
      int stray;

      function void clear();
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            und_tab[k] = 0;
            dis_tab[k] = 0;
         end
         out_w = 480; out_h = 270; scale = 1024;
         src_w = 1920; src_h = 1080; tab_n = 64;
         mismatches = 0;
         stray = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            CSR_OUT_WIDTH: begin
               out_w = val[12:0];
            end
            CSR_OUT_HEIGHT: begin
               out_h = val[12:0];
            end
            CSR_INV_SCALE: begin
               scale = val;
            end
            CSR_SRC_WIDTH: begin
               src_w = val[12:0];
            end
            CSR_SRC_HEIGHT: begin
               src_h = val[12:0];
            end
            CSR_TABLE_COUNT: begin
               tab_n = val[6:0];
            end
            default: begin
            end
         endcase
      endfunction

      function longint isqrt(longint unsigned v);
         longint unsigned res, bt;
         res = 0;
         bt = 64'd1 << 62;
         while (bt > v) bt >>= 2;
         while (bt != 0) begin
            if (v >= res + bt) begin
               v -= res + bt;
               res = (res >> 1) + bt;
            end else begin
               res >>= 1;
            end
            bt >>= 2;
         end
         return res;
      endfunction

      function longint round_div(longint n, longint d);
         longint q;
         q = ((n < 0 ? -n : n) + d / 2) / d;
         return n < 0 ? -q : q;
      endfunction

      function logic [23:0] clip24(longint v);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         return v[23:0];
      endfunction

      function longint radial_height(longint r);
         int n, i;
         longint xl, xr, yl, yr, den;
         n = tab_n;
         if (n < 2) n = 2;
         if (n > TABLE_DEPTH) n = TABLE_DEPTH;
         i = 0;
         if (r >= 2 * longint'(und_tab[n-2])) begin
            i = n - 2;
         end else begin
            while (i < n - 2 && r > 2 * longint'(und_tab[i+1])) i++;
         end
         xl = 2 * longint'(und_tab[i]);
         xr = 2 * longint'(und_tab[i+1]);
         yl = dis_tab[i];
         yr = dis_tab[i+1];
         if (r < xl) yr = yl;
         if (r > xr) yl = yr;
         den = xr - xl;
         if (yl == yr || den <= 0) return yl;
         return yl + round_div((yr - yl) * (r - xl), den);
      endfunction

      // note one accepted input transaction
      function void note_input(logic mode, logic [5:0] idx, logic [23:0] uh, logic [23:0] dh,
                               logic [11:0] c, logic [11:0] rw);
         longint x, y, r, rd, mx, my;
         map_point_type p;
         if (mode == 1'b0) begin
            und_tab[idx] = uh;
            dis_tab[idx] = dh;
            return;
         end
         x = (2 * longint'(c) - longint'(out_w)) * longint'(scale);
         y = (2 * longint'(rw) - longint'(out_h)) * longint'(scale);
         r = isqrt(x * x + y * y);
         mx = longint'(src_w) * 128;
         my = longint'(src_h) * 128;
         if (r > 0) begin
            rd = radial_height(r);
            mx += round_div(x * rd, r);
            my += round_div(y * rd, r);
         end
         p.map_x = clip24(mx);
         p.map_y = clip24(my);
         pending = {pending, p};
      endfunction

      // check one accepted result against the oldest prediction
      function void check_result(logic [23:0] ax, logic [23:0] ay);
         map_point_type p;
         if (pending.size() == 0) begin
            stray++;
            if (mismatches < 10) $display("unexpected result x=%h y=%h", ax, ay);
            mismatches++;
            return;
         end
         p = pending.pop_front();
         if (p.map_x !== ax || p.map_y !== ay) begin
            if (mismatches < 10)
               $display("mismatch: expected x=%h y=%h, got x=%h y=%h",
                        p.map_x, p.map_y, ax, ay);
            mismatches++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_mode;
   logic [5:0] req_entry_index;
   logic [23:0] req_undistorted_height, req_distorted_height;
   logic [11:0] req_col, req_row;
   logic rsp_valid, rsp_ready;
   logic signed [23:0] rsp_map_x, rsp_map_y;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_data;

   map_scoreboard board;
   bit calm;         // no idling in the last part
   bit hold_rsp;     // long receiver hold-off
   int unsigned cycles;
   int unsigned written_top;  // entries 0..written_top-1 have been loaded

   radial_lut_undistort_map dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("radial_lut_undistort_map_test: FAIL");
         $finish;
      end
   end

   // drain results with random stalls
   initial begin
      int gap;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   // check accepted results
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_map_x, rsp_map_y);
   end

   // send one input transaction and note it when accepted; valid drops in the next idle or settle
   task automatic send_item(logic mode, logic [5:0] idx, logic [23:0] uh, logic [23:0] dh,
                            logic [11:0] c, logic [11:0] rw);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_entry_index <= idx;
      req_undistorted_height <= uh;
      req_distorted_height <= dh;
      req_col <= c;
      req_row <= rw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_input(mode, idx, uh, dh, c, rw);
   endtask

   // one register write; the caller drops valid after the last one
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, val);
   endtask

   // wait for every prediction to be met, then let a map finish its latency
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic load_table(int n, bit ascending);
      int unsigned u;
      u = 0;
      for (int k = 0; k < n; k++) begin
         if (ascending) u += $urandom_range(0, 40000);
         else u = $urandom_range(0, 24'hFFFFFF);
         send_item(0, 6'(k), u[23:0],
                   24'($urandom_range(0, 24'hFFFFFF) & (k[0] ? 24'hFFFFFF : 24'h3FFFF)),
                   12'($urandom), 12'($urandom));
      end
      if (n > written_top) written_top = n;
   endtask

   task automatic set_all(int ow, int oh, int sc, int sw, int sh, int tn);
      write_reg(CSR_OUT_WIDTH, 16'(ow));
      write_reg(CSR_OUT_HEIGHT, 16'(oh));
      write_reg(CSR_INV_SCALE, 16'(sc));
      write_reg(CSR_SRC_WIDTH, 16'(sw));
      write_reg(CSR_SRC_HEIGHT, 16'(sh));
      write_reg(CSR_TABLE_COUNT, 16'(tn));
      csr_valid <= 0;
   endtask

   task automatic random_maps(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_item(0, 6'($urandom_range(0, written_top - 1)), 24'($urandom), 24'($urandom),
                      12'($urandom), 12'($urandom));
         else
            send_item(1, 6'($urandom), 24'($urandom), 24'($urandom),
                      12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      end
   endtask

   initial begin
      int tn;
      board = new();
      board.clear();
      calm = 0;
      hold_rsp = 0;
      cycles = 0;
      written_top = 0;
      reset = 1;
      req_valid = 0; req_mode = 0; req_entry_index = 0;
      req_undistorted_height = 0; req_distorted_height = 0; req_col = 0; req_row = 0;
      csr_valid = 0; csr_index = CSR_OUT_WIDTH; csr_data = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: full table, extremes of fields, radius zero, zero scale
      load_table(TABLE_DEPTH, 1);
      send_item(0, 63, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
      send_item(0, 62, 24'hFFFFFF, 24'h000000, 0, 0);
      send_item(1, 0, 0, 0, 240, 135);
      send_item(1, 0, 0, 0, 0, 0);
      send_item(1, 0, 0, 0, 4095, 4095);
      send_item(1, 0, 0, 0, 4095, 0);
      send_item(1, 0, 0, 0, 0, 4095);
      settle();
      set_all(1, 1, 0, 1, 1, 2);
      send_item(1, 0, 0, 0, 7, 3);
      settle();
      set_all(4096, 4096, 65535, 4096, 4096, 127);
      send_item(1, 0, 0, 0, 0, 0);
      send_item(1, 0, 0, 0, 2048, 2048);
      send_item(1, 0, 0, 0, 4095, 100);
      settle();
      // flat segment and non-ascending table
      set_all(64, 64, 256, 64, 64, 4);
      send_item(0, 0, 0, 100, 0, 0);
      send_item(0, 1, 2000, 500, 0, 0);
      send_item(0, 2, 2000, 800, 0, 0);
      send_item(0, 3, 1000, 900, 0, 0);
      send_item(1, 0, 0, 0, 32 + 8, 32);
      send_item(1, 0, 0, 0, 50, 60);
      send_item(1, 0, 0, 0, 0, 0);
      settle();
      set_all(480, 270, 1024, 1920, 1080, 1);
      send_item(1, 0, 0, 0, 10, 10);

      // receiver holds off while the sender keeps offering
      hold_rsp = 1;
      fork
         begin
            repeat (2000) @(posedge clock);
            hold_rsp = 0;
         end
         random_maps(6);
      join
      settle();

      // random phases across settings
      for (int ph = 0; ph < 8; ph++) begin
         tn = $urandom_range(2, 64);
         set_all($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 65535),
                 $urandom_range(1, 4096), $urandom_range(1, 4096), tn);
         load_table(tn, $urandom_range(0, 3) != 0);
         if (ph == 7) calm = 1;
         random_maps(60);
         settle();
      end

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("radial_lut_undistort_map_test: PASS");
      else
         $display("radial_lut_undistort_map_test: FAIL");
      $finish;
   end
endmodule
